FILE: hdl/mwsd_pkg.sv
// Shared types and constants for the multi-word substring detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mwsd_pkg;

    // Fixed register file layout
    localparam int SLOT_REGS      = 6;
    localparam int WORD_BITS      = 64;
    localparam int LEN_BITS       = 4;
    localparam int LENGTHS_BITS   = SLOT_REGS * LEN_BITS;
    localparam int CFG_INDEX_BITS = 3;

    // Register index of the length register; indexes below it select a word slot
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LENGTHS = 3'd6;

    // Stream widths
    localparam int BYTE_BITS  = 8;
    localparam int TDATA_BITS = 8;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // One classified word of the message
    typedef struct packed {
        logic [BYTE_BITS-1:0] text_byte;
        logic                 last;
        logic                 nul;
    } t_entry;

    typedef logic [SLOT_REGS-1:0][WORD_BITS-1:0] t_word_regs;

endpackage

FILE: hdl/mwsd_front.sv
// Front end: accepts message words, classifies them and queues them.
// Depends on mwsd_pkg.
`timescale 1ns / 1ps

module mwsd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [mwsd_pkg::BYTE_BITS-1:0]   i_text_byte,
    input  logic                             i_last,
    output logic                             o_valid,
    output mwsd_pkg::t_entry                 o_entry,
    input  logic                             i_pop
);
    import mwsd_pkg::*;

    t_entry                 r_queue [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0]   r_count, n_count;
    logic                   push, pop;
    t_entry                 new_entry;

    assign o_ready = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_queue[r_rd_ptr];

    assign push = i_valid && o_ready;
    assign pop  = i_pop && o_valid;

    // a zero byte terminates the string
    always_comb begin
        new_entry.text_byte = i_text_byte;
        new_entry.last      = i_last;
        new_entry.nul       = (i_text_byte == '0);
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_entry;
        end
    end

endmodule

FILE: hdl/mwsd_back.sv
// Back end: byte window, parallel compare against all enabled words,
// sticky match flag and the registered result stage. Depends on mwsd_pkg.
`timescale 1ns / 1ps

module mwsd_back #(
    parameter int WORD_COUNT     = 6,
    parameter int MAX_WORD_BYTES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  mwsd_pkg::t_entry                    i_entry,
    output logic                                o_pop,
    input  mwsd_pkg::t_word_regs                i_words,
    input  logic [mwsd_pkg::LENGTHS_BITS-1:0]   i_lengths,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_word_found
);
    import mwsd_pkg::*;

    localparam int LIM = MAX_WORD_BYTES - 1;
    localparam int WIN = (LIM > 0) ? LIM : 1;
    localparam int HW  = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;

    logic [BYTE_BITS-1:0]   r_recent [WIN];
    logic [BYTE_BITS-1:0]   n_recent [WIN];
    logic [HW-1:0]          r_held, n_held;
    logic                   r_ended, n_ended;
    logic                   r_match, n_match;
    logic                   r_out_valid;
    logic                   r_found;

    logic [BYTE_BITS-1:0]   cand [MAX_WORD_BYTES];
    logic                   hit;
    logic                   advance;
    logic                   found;
    logic [LEN_BITS-1:0]    len;
    logic                   ok;

    // a word without last needs no result slot; a last word needs the
    // output register free or draining this cycle
    assign o_pop   = i_valid && (!i_entry.last || !r_out_valid || i_ready);
    assign advance = o_pop && !r_ended && !i_entry.nul;

    // candidate bytes: newest first
    always_comb begin
        cand[0] = i_entry.text_byte;
        for (int j = 1; j < MAX_WORD_BYTES; j++) begin
            cand[j] = r_recent[j-1];
        end
    end

    // a word of length L ends here when its byte k equals cand[L-1-k]
    always_comb begin
        hit = 1'b0;
        len = '0;
        ok  = 1'b0;
        for (int s = 0; s < WORD_COUNT; s++) begin
            len = i_lengths[s*LEN_BITS +: LEN_BITS];
            for (int l = 1; l <= MAX_WORD_BYTES; l++) begin
                if (len == LEN_BITS'(l)) begin
                    ok = (r_held >= HW'(l - 1));
                    for (int k = 0; k < l; k++) begin
                        if (i_words[s][k*BYTE_BITS +: BYTE_BITS] != cand[l-1-k]) begin
                            ok = 1'b0;
                        end
                    end
                    if (ok) begin
                        hit = 1'b1;
                    end
                end
            end
        end
    end

    assign found = r_match || (advance && hit);

    always_comb begin
        n_recent = r_recent;
        n_held   = r_held;
        n_ended  = r_ended;
        n_match  = r_match;
        if (o_pop) begin
            if (i_entry.last) begin
                n_held  = '0;
                n_ended = 1'b0;
                n_match = 1'b0;
            end else begin
                n_match = found;
                if (!r_ended && i_entry.nul) begin
                    n_ended = 1'b1;
                end
                if (advance && LIM > 0) begin
                    for (int i = WIN - 1; i > 0; i--) begin
                        n_recent[i] = r_recent[i-1];
                    end
                    n_recent[0] = i_entry.text_byte;
                    if (r_held < HW'(LIM)) begin
                        n_held = r_held + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_ended     <= 1'b0;
            r_match     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_held  <= n_held;
            r_ended <= n_ended;
            r_match <= n_match;
            if (o_pop && i_entry.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window bytes above the fill count are never compared
    always_ff @(posedge i_clk) begin
        r_recent <= n_recent;
        if (o_pop && i_entry.last) begin
            r_found <= found;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_word_found = r_found;

endmodule

FILE: hdl/multi_word_substring_detector_unit.sv
// Flow: an accepted word is queued in the front end, compared when the back
//   end pops it, and a last word's result is registered on that pop.
// Throughput: one word per cycle from the back-end window compare, unless a
//   last word waits on a busy result register; a 4-entry queue absorbs output stalls.
// Reset: synchronous, active low; clears word registers, lengths, window
//   fill and flags, queue pointers and result valid, but not window bytes.
`timescale 1ns / 1ps

module multi_word_substring_detector_unit #(
    parameter int WORD_COUNT     = 6,
    parameter int MAX_WORD_BYTES = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [mwsd_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [mwsd_pkg::WORD_BITS-1:0]        i_cfg_wdata,
    // message words in
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [mwsd_pkg::TDATA_BITS-1:0]       s_axis_tdata,  // [7:0] text_byte
    input  logic                                  s_axis_tlast,  // last_byte
    // results out
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [mwsd_pkg::TDATA_BITS-1:0]       m_axis_tdata   // [0] word_found, rest 0
);
    import mwsd_pkg::*;

    // word slots and packed lengths; slots at or above WORD_COUNT are
    // writable but never compared
    t_word_regs                r_words;
    logic [LENGTHS_BITS-1:0]   r_lengths;

    logic     q_valid;
    t_entry   q_entry;
    logic     q_pop;
    logic     found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words   <= '0;
            r_lengths <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index < CFG_LENGTHS) begin
                r_words[i_cfg_index] <= i_cfg_wdata;
            end else if (i_cfg_index == CFG_LENGTHS) begin
                r_lengths <= i_cfg_wdata[LENGTHS_BITS-1:0];
            end
        end
    end

    // front: accept, flag zero bytes, queue
    mwsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_text_byte (s_axis_tdata[BYTE_BITS-1:0]),
        .i_last      (s_axis_tlast),
        .o_valid     (q_valid),
        .o_entry     (q_entry),
        .i_pop       (q_pop)
    );

    // back: window compare, sticky flag, result register
    mwsd_back #(
        .WORD_COUNT     (WORD_COUNT),
        .MAX_WORD_BYTES (MAX_WORD_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_entry      (q_entry),
        .o_pop        (q_pop),
        .i_words      (r_words),
        .i_lengths    (r_lengths),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_word_found (found)
    );

    assign m_axis_tdata = {{(TDATA_BITS-1){1'b0}}, found};

endmodule
